// File: rtl/gdm_pkg.sv
// Package with shared constants, types and helpers for the descriptor matcher.
package gdm_pkg;
  localparam int MaxModels = 64;
  localparam int MaxLength = 256;
  localparam int ElemW = 16;
  localparam int IdxW = $clog2(MaxModels);
  localparam int CntW = $clog2(MaxModels + 1);
  localparam int PosW = $clog2(MaxLength);
  localparam int LenW = 9;
  localparam int DistW = 40;
  localparam int AddrW = IdxW + PosW;
  localparam logic [DistW-1:0] DistCap = {DistW{1'b1}};
  localparam logic [DistW-1:0] RefLimit = 40'd65536000;
  localparam logic [DistW-1:0] ThreshReset = 40'd163840;
  localparam logic [LenW-1:0] LengthReset = 9'd162;

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_MODEL = 2'd1,
    ACT_QUERY = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  localparam logic CFG_THRESHOLD = 1'b0;
  localparam logic CFG_LENGTH = 1'b1;

  // Token that travels down the cell chain, one cell per cycle.
  typedef struct packed {
    logic              vld;
    logic [ElemW-1:0]  query;
    logic              last;
    logic              found;
    logic [IdxW-1:0]   best_idx;
    logic [DistW-1:0]  best;
  } token_t;

  // Square of the difference of two elements; it always fits below the cap.
  function automatic logic [DistW-1:0] sq_term(input logic signed [ElemW-1:0] a,
                                               input logic signed [ElemW-1:0] b);
    logic signed [ElemW:0] d;
    logic [ElemW:0] ad;
    logic [2*ElemW+1:0] p;
    begin
      d = {a[ElemW-1], a} - {b[ElemW-1], b};
      ad = d[ElemW] ? (ElemW+1)'(-d) : (ElemW+1)'(d);
      p = ad * ad;
      sq_term = DistW'(p);
    end
  endfunction
endpackage

// File: rtl/gdm_if.sv
// Valid/ready channel interfaces for items, results and configuration.
interface gdm_in_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                action;
  logic [gdm_pkg::ElemW-1:0] element_value;
  modport source (output valid, action, element_value, input ready);
  modport sink (input valid, action, element_value, output ready);
endinterface

interface gdm_out_if;
  logic                      valid;
  logic                      ready;
  logic                      matched;
  logic [gdm_pkg::IdxW-1:0]  model_index;
  logic [gdm_pkg::DistW-1:0] best_distance;
  modport source (output valid, matched, model_index, best_distance, input ready);
  modport sink (input valid, matched, model_index, best_distance, output ready);
endinterface

interface gdm_cfg_if;
  logic                      valid;
  logic                      ready;
  logic                      index;
  logic [gdm_pkg::DistW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/gdm_cell.sv
// One model cell: holds a distance sum and taken mark, updates the passing token.
module gdm_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      clr,
  input  logic                      active,
  input  logic [gdm_pkg::IdxW-1:0]  my_idx,
  input  logic [gdm_pkg::ElemW-1:0] model_elem,
  input  logic [gdm_pkg::DistW-1:0] thresh,
  input  logic                      take_vld,
  input  logic [gdm_pkg::IdxW-1:0]  take_idx,
  input  gdm_pkg::token_t           tok_in,
  output gdm_pkg::token_t           tok_out
);
  logic [gdm_pkg::DistW-1:0] sum_r, sum_nxt;
  logic taken_r, taken_nxt;
  gdm_pkg::token_t tok_r, tok_nxt;
  logic [gdm_pkg::DistW:0] s;
  logic cand;

  // Accumulate, then on the last element compete for the best free model.
  always_comb begin
    sum_nxt = sum_r;
    taken_nxt = taken_r || (take_vld && (take_idx == my_idx));
    tok_nxt = tok_in;
    s = {1'b0, sum_r} + {1'b0, gdm_pkg::sq_term(tok_in.query, model_elem)};
    cand = 1'b0;
    if (tok_in.vld && active) begin
      if (tok_in.last) begin
        cand = !taken_r && (s[gdm_pkg::DistW-1:0] < thresh) && !s[gdm_pkg::DistW]
               && (s[gdm_pkg::DistW-1:0] < gdm_pkg::RefLimit)
               && (!tok_in.found || s[gdm_pkg::DistW-1:0] < tok_in.best);
        sum_nxt = '0;
        if (cand) begin
          tok_nxt.found = 1'b1;
          tok_nxt.best = s[gdm_pkg::DistW-1:0];
          tok_nxt.best_idx = my_idx;
        end
      end else begin
        sum_nxt = s[gdm_pkg::DistW] ? gdm_pkg::DistCap : s[gdm_pkg::DistW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      sum_r <= '0;
      taken_r <= 1'b0;
      tok_r.vld <= 1'b0;
    end else begin
      sum_r <= sum_nxt;
      taken_r <= taken_nxt;
      tok_r <= tok_nxt;
    end
  end

  assign tok_out = tok_r;
endmodule

// File: rtl/gdm_ctrl.sv
// Sequencer: takes items, steps the token through the cells, reads the model store.
module gdm_ctrl (
  input  logic clk,
  input  logic rst_n,
  gdm_in_if.sink  in_ch,
  gdm_out_if.source out_ch,
  gdm_cfg_if.sink cfg_ch
);
  localparam int N = gdm_pkg::MaxModels;
  typedef enum logic [1:0] {S_IDLE, S_RUN, S_OUT} state_t;
  state_t state_r;

  logic [gdm_pkg::DistW-1:0] thresh_r;
  logic [gdm_pkg::LenW-1:0] len_r;
  logic [gdm_pkg::CntW-1:0] count_r;
  logic [gdm_pkg::PosW:0] pos_r;
  logic [gdm_pkg::IdxW-1:0] step_r;
  logic [gdm_pkg::ElemW-1:0] store [0:N*gdm_pkg::MaxLength-1];
  logic [gdm_pkg::ElemW-1:0] rd_r;
  logic [gdm_pkg::PosW-1:0] qpos_r;
  logic clr_r;
  gdm_pkg::token_t tok [0:N];
  gdm_pkg::token_t head_r;
  logic [gdm_pkg::DistW-1:0] res_best_r;
  logic [gdm_pkg::IdxW-1:0] res_idx_r;
  logic res_found_r;

  logic [gdm_pkg::LenW-1:0] eff_len;
  logic last;
  logic [gdm_pkg::ElemW-1:0] cell_elem [0:N-1];
  logic [gdm_pkg::IdxW-1:0] rd_idx;
  logic [gdm_pkg::PosW-1:0] rd_pos;
  logic take_vld;
  logic [gdm_pkg::IdxW-1:0] take_idx;

  always_comb begin
    eff_len = (len_r == '0) ? gdm_pkg::LenW'(1) :
              (len_r > gdm_pkg::LenW'(gdm_pkg::MaxLength)) ?
              gdm_pkg::LenW'(gdm_pkg::MaxLength) : len_r;
    last = ({1'b0, pos_r} + 10'd1) >= {1'b0, eff_len};
  end

  assign in_ch.ready = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = (state_r == S_OUT);
  assign out_ch.matched = res_found_r;
  assign out_ch.model_index = res_found_r ? 6'(res_idx_r) : 6'd0;
  assign out_ch.best_distance = res_found_r ? res_best_r : '0;

  // Token enters cell 0 once; the store word for a cell is read the cycle before.
  // While idle the read serves cell 0, while running the cell after the token.
  assign tok[0] = head_r;
  assign rd_idx = (state_r == S_RUN) ? step_r + 1'b1 : '0;
  assign rd_pos = (state_r == S_RUN) ? qpos_r : pos_r[gdm_pkg::PosW-1:0];

  // The winner of a finished query is marked taken in its cell.
  assign take_vld = (state_r == S_RUN) && tok[N].vld && tok[N].last && tok[N].found;
  assign take_idx = tok[N].best_idx;

  // Store read: one model word per cycle, addressed by the cell the token reaches next.
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready && in_ch.action == gdm_pkg::ACT_MODEL &&
        count_r < gdm_pkg::CntW'(N) && !pos_r[gdm_pkg::PosW])
      store[{count_r[gdm_pkg::IdxW-1:0], pos_r[gdm_pkg::PosW-1:0]}] <= in_ch.element_value;
    rd_r <= store[{rd_idx, rd_pos}];
  end

  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_cell
      assign cell_elem[g] = rd_r;
      gdm_cell u_cell (
        .clk(clk), .rst_n(rst_n), .clr(clr_r),
        .active(gdm_pkg::CntW'(g) < count_r),
        .my_idx(gdm_pkg::IdxW'(g)),
        .model_elem(cell_elem[g]),
        .thresh(thresh_r),
        .take_vld(take_vld),
        .take_idx(take_idx),
        .tok_in(tok[g]),
        .tok_out(tok[g+1])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      thresh_r <= gdm_pkg::ThreshReset;
      len_r <= gdm_pkg::LengthReset;
      count_r <= '0;
      pos_r <= '0;
      step_r <= '0;
      clr_r <= 1'b0;
      head_r.vld <= 1'b0;
      res_found_r <= 1'b0;
      qpos_r <= '0;
    end else begin
      clr_r <= 1'b0;
      head_r.vld <= 1'b0;
      if (cfg_ch.valid) begin
        if (cfg_ch.index == gdm_pkg::CFG_THRESHOLD) thresh_r <= cfg_ch.data;
        else if (cfg_ch.index == gdm_pkg::CFG_LENGTH)
          len_r <= cfg_ch.data[gdm_pkg::LenW-1:0];
      end
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            case (in_ch.action)
              gdm_pkg::ACT_CLEAR: begin
                count_r <= '0;
                pos_r <= '0;
                clr_r <= 1'b1;
              end
              gdm_pkg::ACT_MODEL: begin
                if (last) begin
                  pos_r <= '0;
                  if (count_r < gdm_pkg::CntW'(N)) count_r <= count_r + 1'b1;
                end else pos_r <= pos_r + 1'b1;
              end
              gdm_pkg::ACT_QUERY: begin
                qpos_r <= pos_r[gdm_pkg::PosW-1:0];
                head_r.vld <= !pos_r[gdm_pkg::PosW];
                head_r.query <= in_ch.element_value;
                head_r.last <= last;
                head_r.found <= 1'b0;
                head_r.best_idx <= '0;
                head_r.best <= '0;
                step_r <= '0;
                res_found_r <= 1'b0;
                pos_r <= last ? '0 : pos_r + 1'b1;
                state_r <= S_RUN;
              end
              default: ;
            endcase
          end
        end
        S_RUN: begin
          // Token is in cell step_r; the next cell's element is being read.
          step_r <= step_r + 1'b1;
          if (tok[N].vld) begin
            res_found_r <= tok[N].found;
            res_idx_r <= tok[N].best_idx;
            res_best_r <= tok[N].best;
            state_r <= tok[N].last ? S_OUT : S_IDLE;
          end
        end
        S_OUT: if (out_ch.ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// File: rtl/greedy_descriptor_matcher_top.sv
// Top level of the greedy descriptor matcher.
// Model and query vectors arrive one element per transaction and share one
// position counter; model, clear and unused-code transactions are taken
// without leaving the idle state. A query element walks a chain of 64 cells,
// one cell per cycle, and the input stays blocked until the token has left
// the last cell; on a vector's last element the result register then holds
// the result until out_ready. Each query vector yields one result with the
// lowest-index free model of smallest distance. Write the configuration
// registers only while no transaction is in flight.
module greedy_descriptor_matcher_top (
  input logic clk,
  input logic rst_n,
  gdm_in_if.sink  in_ch,
  gdm_out_if.source out_ch,
  gdm_cfg_if.sink cfg_ch
);
  // The controller owns the cell chain and the model store.
  gdm_ctrl u_ctrl (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch));
endmodule

// File: rtl/gdm_checker.sv
// Port checker for the descriptor matcher, bound to the top level.
module gdm_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic matched,
  input logic [5:0] model_index,
  input logic [39:0] best_distance
);
  a_nomatch_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !matched |-> model_index == 6'd0 && best_distance == 40'd0) else $error("nz");
  a_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && matched |-> best_distance < 40'd65536000) else $error("limit");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("excl");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(best_distance)) else $error("hold");
endmodule

bind greedy_descriptor_matcher_top gdm_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .matched(out_ch.matched),
  .model_index(out_ch.model_index), .best_distance(out_ch.best_distance));
